/* src/bpa_pkg.sv */
// bpa_pkg: shared types, register codes and helpers of the bitmap page allocator
// used by every module under src but bpa_fifo; depends on nothing
package bpa_pkg;

    // fixed widths of the register file and the word fields
    localparam int REG_POOLS  = 3;
    localparam int ADDR_W     = 32;
    localparam int PAGES_W    = 11;
    localparam int SHIFT_W    = 5;
    localparam int SHIFTS_W   = 15;
    localparam int POOL_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SHIFTS_W-1:0] SHIFTS_RESET = 15'd10638;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL0_BASE  = 3'd0,
        REG_POOL0_PAGES = 3'd1,
        REG_POOL1_BASE  = 3'd2,
        REG_POOL1_PAGES = 3'd3,
        REG_POOL2_BASE  = 3'd4,
        REG_POOL2_PAGES = 3'd5,
        REG_PAGE_SHIFTS = 3'd6
    } t_reg_idx;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOFREE   = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_BADPOOL  = 2'd3
    } t_status;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_RESULT = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [POOL_W-1:0] pool;
        t_status           status;
    } t_cmd;

    // live configuration seen by front and back
    typedef struct packed {
        logic [REG_POOLS-1:0][ADDR_W-1:0]  base;
        logic [REG_POOLS-1:0][PAGES_W-1:0] pages;
        logic [SHIFTS_W-1:0]               shifts;
    } t_cfg;

    // log2 page size of one pool
    function automatic logic [SHIFT_W-1:0] shift_of(input logic [SHIFTS_W-1:0] shifts,
                                                    input logic [POOL_W-1:0] pool);
        logic [SHIFT_W-1:0] s;
        case (pool)
            2'd0:    s = shifts[4:0];
            2'd1:    s = shifts[9:5];
            2'd2:    s = shifts[14:10];
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

/* src/bitmap_page_allocator.sv */
// bitmap_page_allocator: top level with configuration registers
// depends on bpa_pkg, bpa_front, bpa_fifo and bpa_back
//
//  channel  valid       stall        payload
//  in       i_in_valid  o_in_stall   i_mode, i_pool, i_page_addr
//  out      o_out_valid i_out_stall  o_status, o_alloc_addr
//  cfg      i_cfg_we    (none)       i_cfg_index, i_cfg_data
//
// the front register holds and classifies an accepted word and pushes it into the queue once the queue has room;
// the back steps an allocate or free through idle (summary search and read),
// read (modify-write) and done (address add), skipping read for words answered
// at once or an allocate that finds every word full; it pops a word only in idle
// reset clears the bitmap marks at once; no clearing pass is needed
// either side may stall; a two-entry queue parts front and back
module bitmap_page_allocator #(
    parameter int MAX_PAGES     = 1024,
    parameter int MAP_WORD_BITS = 32,
    parameter int POOL_COUNT    = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [bpa_pkg::POOL_W-1:0]      i_pool,
    input  logic [bpa_pkg::ADDR_W-1:0]      i_page_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [bpa_pkg::ADDR_W-1:0]      o_alloc_addr
);

    localparam int BIT_W  = $clog2(MAP_WORD_BITS + 1) - 1;
    localparam int WB     = 1 << BIT_W;
    localparam int WPP    = (MAX_PAGES + WB - 1) / WB;
    localparam int WORD_W = (WPP > 1) ? $clog2(WPP) : 1;
    localparam int PG_W   = WORD_W + BIT_W;
    localparam int Q_W    = $bits(bpa_pkg::t_cmd) + PG_W;

    bpa_pkg::t_cfg                    r_cfg;
    logic [bpa_pkg::REG_POOLS-1:0]    clear;

    logic                             push;
    logic                             pop;
    logic                             q_full;
    logic                             q_empty;
    bpa_pkg::t_cmd                    f_cmd;
    logic [PG_W-1:0]                  f_page;
    bpa_pkg::t_cmd                    b_cmd;
    logic [PG_W-1:0]                  b_page;
    logic [Q_W-1:0]                   q_out;
    bpa_pkg::t_status                 status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= '0;
            r_cfg.pages  <= '0;
            r_cfg.shifts <= bpa_pkg::SHIFTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpa_pkg::REG_POOL0_BASE:  r_cfg.base[0]  <= i_cfg_data;
                bpa_pkg::REG_POOL0_PAGES: r_cfg.pages[0] <= i_cfg_data[bpa_pkg::PAGES_W-1:0];
                bpa_pkg::REG_POOL1_BASE:  r_cfg.base[1]  <= i_cfg_data;
                bpa_pkg::REG_POOL1_PAGES: r_cfg.pages[1] <= i_cfg_data[bpa_pkg::PAGES_W-1:0];
                bpa_pkg::REG_POOL2_BASE:  r_cfg.base[2]  <= i_cfg_data;
                bpa_pkg::REG_POOL2_PAGES: r_cfg.pages[2] <= i_cfg_data[bpa_pkg::PAGES_W-1:0];
                bpa_pkg::REG_PAGE_SHIFTS: r_cfg.shifts <= i_cfg_data[bpa_pkg::SHIFTS_W-1:0];
                default: ;
            endcase
        end
    end

    // page count writes empty the pool's bitmap
    always_comb begin
        clear = '0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpa_pkg::REG_POOL0_PAGES: clear[0] = 1'b1;
                bpa_pkg::REG_POOL1_PAGES: clear[1] = 1'b1;
                bpa_pkg::REG_POOL2_PAGES: clear[2] = 1'b1;
                default: ;
            endcase
        end
    end

    bpa_front #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .POOL_COUNT    (POOL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_pool      (i_pool),
        .i_page_addr (i_page_addr),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_page      (f_page),
        .i_q_full    (q_full)
    );

    bpa_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_page}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign b_cmd  = bpa_pkg::t_cmd'(q_out[Q_W-1:PG_W]);
    assign b_page = q_out[PG_W-1:0];

    bpa_back #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .POOL_COUNT    (POOL_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_clear      (clear),
        .i_q_empty    (q_empty),
        .i_cmd        (b_cmd),
        .i_page       (b_page),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_alloc_addr (o_alloc_addr)
    );

    assign o_status = status;

endmodule

/* src/bpa_fifo.sv */
// bpa_fifo: two-entry command queue between front and back
// depends on nothing; width set by the instantiating module
module bpa_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_mem [0:1];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* src/bpa_front.sv */
// bpa_front: input register and request classification
// depends on bpa_pkg; feeds classified commands into the queue
module bpa_front #(
    parameter int MAX_PAGES       = 1024,
    parameter int MAP_WORD_BITS   = 32,
    parameter int POOL_COUNT      = 3,
    localparam int BIT_W          = $clog2(MAP_WORD_BITS + 1) - 1,
    localparam int WB             = 1 << BIT_W,
    localparam int WPP            = (MAX_PAGES + WB - 1) / WB,
    localparam int WORD_W         = (WPP > 1) ? $clog2(WPP) : 1,
    localparam int PG_W           = WORD_W + BIT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [bpa_pkg::POOL_W-1:0]    i_pool,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_page_addr,
    output logic                          o_push,
    output bpa_pkg::t_cmd                 o_cmd,
    output logic [PG_W-1:0]               o_page,
    input  logic                          i_q_full
);

    localparam int NPOOL = (POOL_COUNT < bpa_pkg::REG_POOLS) ? POOL_COUNT
                                                             : bpa_pkg::REG_POOLS;
    localparam int CNT_W = ($clog2(MAX_PAGES + 1) > bpa_pkg::PAGES_W)
                         ? $clog2(MAX_PAGES + 1) : bpa_pkg::PAGES_W;

    logic                          r_valid;
    logic                          r_mode;
    logic [bpa_pkg::POOL_W-1:0]    r_pool;
    logic [bpa_pkg::ADDR_W-1:0]    r_addr;

    logic                          accept;
    logic                          bad_pool;
    logic [bpa_pkg::ADDR_W-1:0]    base;
    logic [CNT_W-1:0]              pages;
    logic [CNT_W-1:0]              n_eff;
    logic [bpa_pkg::ADDR_W-1:0]    diff;
    logic [bpa_pkg::ADDR_W-1:0]    pg;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    // held word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_pool <= i_pool;
            r_addr <= i_page_addr;
        end
    end

    // pool lookups and free range check
    always_comb begin
        bad_pool = (3'(r_pool) >= 3'(NPOOL));
        base     = i_cfg.base[r_pool];
        pages    = CNT_W'(i_cfg.pages[r_pool]);
        n_eff    = (pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pages;
        diff     = r_addr - base;
        pg       = diff >> bpa_pkg::shift_of(i_cfg.shifts, r_pool);
    end

    // classification
    always_comb begin
        o_cmd.pool   = r_pool;
        o_cmd.kind   = bpa_pkg::CMD_RESULT;
        o_cmd.status = bpa_pkg::ST_DONE;
        o_page       = PG_W'(pg);
        if (bad_pool) begin
            o_cmd.status = bpa_pkg::ST_BADPOOL;
        end else if (!r_mode) begin
            o_cmd.kind = bpa_pkg::CMD_ALLOC;
        end else if (r_addr == '0 || r_addr < base) begin
            o_cmd.status = bpa_pkg::ST_IGNORED;
        end else if (pg >= 32'(n_eff)) begin
            o_cmd.status = bpa_pkg::ST_IGNORED;
        end else begin
            o_cmd.kind = bpa_pkg::CMD_FREE;
        end
    end

endmodule

/* src/bpa_back.sv */
// bpa_back: bitmap memory, full-word summary and allocate/free sequencer
// depends on bpa_pkg; drains the command queue and drives the result word
module bpa_back #(
    parameter int MAX_PAGES       = 1024,
    parameter int MAP_WORD_BITS   = 32,
    parameter int POOL_COUNT      = 3,
    localparam int BIT_W          = $clog2(MAP_WORD_BITS + 1) - 1,
    localparam int WB             = 1 << BIT_W,
    localparam int WPP            = (MAX_PAGES + WB - 1) / WB,
    localparam int WORD_W         = (WPP > 1) ? $clog2(WPP) : 1,
    localparam int PG_W           = WORD_W + BIT_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpa_pkg::t_cfg                    i_cfg,
    input  logic [bpa_pkg::REG_POOLS-1:0]    i_clear,
    input  logic                             i_q_empty,
    input  bpa_pkg::t_cmd                    i_cmd,
    input  logic [PG_W-1:0]                  i_page,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bpa_pkg::t_status                 o_status,
    output logic [bpa_pkg::ADDR_W-1:0]       o_alloc_addr
);

    localparam int WORDS  = 1 << WORD_W;
    localparam int NPOOL  = (POOL_COUNT < bpa_pkg::REG_POOLS) ? POOL_COUNT
                                                              : bpa_pkg::REG_POOLS;
    localparam int PI_W   = (NPOOL > 1) ? $clog2(NPOOL) : 1;
    localparam int DEPTH  = NPOOL * WORDS;
    localparam int MA_W   = $clog2(DEPTH);
    localparam int CNT_W  = ($clog2(MAX_PAGES + 1) > bpa_pkg::PAGES_W)
                          ? $clog2(MAX_PAGES + 1) : bpa_pkg::PAGES_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    bpa_pkg::t_cmd_kind           r_kind;
    logic [bpa_pkg::POOL_W-1:0]   r_pool;
    logic [WORD_W-1:0]            r_word;
    logic [BIT_W-1:0]             r_bit;
    logic [PG_W-1:0]              r_page;
    logic                         r_alloc;
    bpa_pkg::t_status             r_status;

    // bitmap words, per-word written marks and all-used summary
    logic [WB-1:0]                r_mem [0:DEPTH-1];
    logic [WB-1:0]                r_rdata;
    logic                         r_rvalid;
    logic [WORDS-1:0]             r_mvalid [0:NPOOL-1];
    logic [WORDS-1:0]             r_full   [0:NPOOL-1];

    logic [PI_W-1:0]              cmd_pidx;
    logic [PI_W-1:0]              pidx;
    logic                         free_hit;
    logic [WORD_W-1:0]            free_word;
    logic [WORD_W-1:0]            rd_word;
    logic                         mem_re;
    logic                         mem_we;
    logic [WB-1:0]                word_data;
    logic [WB-1:0]                new_word;
    logic [BIT_W-1:0]             zero_bit;
    logic [PG_W-1:0]              pick_page;
    logic [CNT_W-1:0]             pages;
    logic [CNT_W-1:0]             n_eff;
    logic                         can_out;

    assign cmd_pidx  = PI_W'(i_cmd.pool);
    assign pidx      = PI_W'(r_pool);
    assign can_out   = !o_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign word_data = r_rvalid ? r_rdata : '0;

    // lowest word of the requested pool that still has a free page
    always_comb begin
        free_hit  = 1'b0;
        free_word = '0;
        for (int i = WPP - 1; i >= 0; i--) begin
            if (!r_full[cmd_pidx][i]) begin
                free_hit  = 1'b1;
                free_word = WORD_W'(i);
            end
        end
    end

    // lowest clear bit of the word just read
    always_comb begin
        zero_bit = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (!word_data[i]) begin
                zero_bit = BIT_W'(i);
            end
        end
    end

    // page count limit of the active pool
    always_comb begin
        pages     = CNT_W'(i_cfg.pages[r_pool]);
        n_eff     = (pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pages;
        pick_page = {r_word, zero_bit};
    end

    // read issue and modify-write decisions
    always_comb begin
        mem_re   = 1'b0;
        rd_word  = free_word;
        mem_we   = 1'b0;
        new_word = word_data;
        if (o_pop && i_cmd.kind == bpa_pkg::CMD_FREE) begin
            mem_re  = 1'b1;
            rd_word = i_page[PG_W-1:BIT_W];
        end else if (o_pop && i_cmd.kind == bpa_pkg::CMD_ALLOC && free_hit) begin
            mem_re = 1'b1;
        end
        if (r_state == S_READ) begin
            if (r_kind == bpa_pkg::CMD_FREE) begin
                mem_we   = 1'b1;
                new_word = word_data & ~(WB'(1) << r_bit);
            end else if (32'(pick_page) < 32'(n_eff)) begin
                mem_we   = 1'b1;
                new_word = word_data | (WB'(1) << zero_bit);
            end
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[MA_W'({pidx, r_word})] <= new_word;
        end
        if (mem_re) begin
            r_rdata  <= r_mem[MA_W'({cmd_pidx, rd_word})];
            r_rvalid <= r_mvalid[cmd_pidx][rd_word];
        end
    end

    // written marks and full summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NPOOL; p++) begin
                r_mvalid[p] <= '0;
                r_full[p]   <= '0;
            end
        end else begin
            for (int p = 0; p < NPOOL; p++) begin
                if (i_clear[p]) begin
                    r_mvalid[p] <= '0;
                    r_full[p]   <= '0;
                end
            end
            if (mem_we) begin
                r_mvalid[pidx][r_word] <= 1'b1;
                r_full[pidx][r_word]   <= &new_word;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = mem_re ? S_READ : S_DONE;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (can_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // per-command working registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= i_cmd.kind;
            r_pool  <= i_cmd.pool;
            r_word  <= rd_word;
            r_bit   <= i_page[BIT_W-1:0];
            r_alloc <= 1'b0;
            if (i_cmd.kind == bpa_pkg::CMD_ALLOC) begin
                r_status <= bpa_pkg::ST_NOFREE;
            end else begin
                r_status <= i_cmd.status;
            end
        end else if (r_state == S_READ) begin
            r_page <= pick_page;
            if (r_kind == bpa_pkg::CMD_FREE) begin
                r_status <= bpa_pkg::ST_DONE;
            end else if (mem_we) begin
                r_status <= bpa_pkg::ST_DONE;
                r_alloc  <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_DONE && can_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && can_out) begin
            o_status <= r_status;
            if (r_alloc) begin
                o_alloc_addr <= i_cfg.base[r_pool]
                    + (32'(r_page) << bpa_pkg::shift_of(i_cfg.shifts, r_pool));
            end else begin
                o_alloc_addr <= '0;
            end
        end
    end

endmodule
